/* hdl/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared codes and the character-to-segment table of the seven-segment
// scroll and blink driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int SEG_W = 7;

	// Command codes carried in the input tuser field
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_MSG   = 2'd2,
		CMD_DISP  = 2'd3
	} ssd_cmd_t;

	// Configuration register indexes
	localparam logic [2:0] REG_BLINK_MODE  = 3'd0;
	localparam logic [2:0] REG_SPIN_EN     = 3'd1;
	localparam logic [2:0] REG_MSG_LEN     = 3'd2;
	localparam logic [2:0] REG_SPIN_DLY    = 3'd3;
	localparam logic [2:0] REG_BLINK_DLY   = 3'd4;
	localparam logic [2:0] REG_DIM_LEVEL   = 3'd5;

	// Blink mode codes
	localparam logic [2:0] BLINK_OFF   = 3'd0;
	localparam logic [2:0] BLINK_EVERY = 3'd5;

	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

	// Map an ASCII code to segment lines a..g (bit 0 is segment a)
	function automatic logic [SEG_W-1:0] ssd_glyph(input logic [7:0] code);
		logic [7:0]       uc;
		logic [SEG_W-1:0] seg;
		uc = code;
		if (code >= 8'h61 && code <= 8'h7A) begin
			uc = code - 8'h20;
		end
		case (uc)
			8'h41: seg = 7'h77; // A
			8'h42: seg = 7'h7C; // B
			8'h43: seg = 7'h39; // C
			8'h44: seg = 7'h5E; // D
			8'h45: seg = 7'h79; // E
			8'h46: seg = 7'h71; // F
			8'h47: seg = 7'h6F; // G
			8'h48: seg = 7'h74; // H
			8'h49: seg = 7'h04; // I
			8'h4A: seg = 7'h1E; // J
			8'h4C: seg = 7'h38; // L
			8'h4E: seg = 7'h54; // N
			8'h4F: seg = 7'h3F; // O
			8'h50: seg = 7'h73; // P
			8'h51: seg = 7'h67; // Q
			8'h52: seg = 7'h50; // R
			8'h53: seg = 7'h6D; // S
			8'h54: seg = 7'h78; // T
			8'h55: seg = 7'h3E; // U
			8'h56: seg = 7'h3E; // V
			8'h59: seg = 7'h6E; // Y
			8'h5A: seg = 7'h7F; // Z
			8'h30: seg = 7'h3F; // 0
			8'h31: seg = 7'h06; // 1
			8'h32: seg = 7'h5B; // 2
			8'h33: seg = 7'h4F; // 3
			8'h34: seg = 7'h66; // 4
			8'h35: seg = 7'h6D; // 5
			8'h36: seg = 7'h7D; // 6
			8'h37: seg = 7'h07; // 7
			8'h38: seg = 7'h7F; // 8
			8'h39: seg = 7'h6F; // 9
			8'h2D: seg = 7'h40; // minus
			8'h3D: seg = 7'h48; // equals
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

/* hdl/ssd_buf.sv */
// ----------------------------------------------------------------------------
// ssd_buf
// Message pattern store: one segment pattern per character position, written
// by load transactions, blanked all at once by a clear, read asynchronously.
// ----------------------------------------------------------------------------
module ssd_buf #(
	parameter int MAX_CHARS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_CHARS)-1:0]   wr_addr,
	input  logic [ssd_pkg::SEG_W-1:0]      wr_data,
	input  logic                           clear,
	input  logic [$clog2(MAX_CHARS)-1:0]   rd_addr,
	output logic [ssd_pkg::SEG_W-1:0]      rd_data
);
	import ssd_pkg::*;

	logic [SEG_W-1:0] mem_q [MAX_CHARS];

	// Blank on reset and clear, store on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHARS; i++) begin
				mem_q[i] <= SEG_BLANK;
			end
		end else if (clear) begin
			for (int i = 0; i < MAX_CHARS; i++) begin
				mem_q[i] <= SEG_BLANK;
			end
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Caller qualifies the address range
	assign rd_data = mem_q[rd_addr];

endmodule

/* hdl/seven_segment_scroll_blink_driver.sv */
// ----------------------------------------------------------------------------
// A display tick goes through the input register, then the result register,
// and waits there until the result stream takes it. Throughput: one
// transaction per cycle on the input stream while the result stream keeps
// up; loads, clears and message ticks give no result and never wait on the
// output.
// Reset: asynchronous, active low; clears the pattern buffer, counters and
// both stream stages, and puts the configuration registers at their defaults.
// ----------------------------------------------------------------------------
// seven_segment_scroll_blink_driver
// Multiplexed seven-segment display driver with message scroll, digit blink
// and PWM dimming.
// ----------------------------------------------------------------------------
module seven_segment_scroll_blink_driver #(
	parameter int DIGITS     = 4,
	parameter int MAX_CHARS  = 32,
	parameter int PWM_PERIOD = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: char_pos, char_code (low to high), zero padded
	input  logic [((($clog2(MAX_CHARS) + 8) + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: cmd
	input  logic [1:0]           s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: digit_sel, segments (low to high), zero padded
	output logic [((($clog2(DIGITS) + 7) + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data
);
	import ssd_pkg::*;

	localparam int POS_W   = $clog2(MAX_CHARS);
	localparam int DIG_W   = $clog2(DIGITS);
	localparam int OUT_W   = (((DIG_W + SEG_W) + 7) / 8) * 8;
	localparam int SCR_W   = $clog2(MAX_CHARS + DIGITS + 2);
	localparam int IW      = SCR_W + 1;
	localparam int PWM_W   = $clog2(PWM_PERIOD + 1);

	// Configuration registers
	logic [2:0] blink_mode_q;
	logic       spin_en_q;
	logic [5:0] msg_len_q;
	logic [7:0] spin_dly_q;
	logic [7:0] blink_dly_q;
	logic [3:0] dim_level_q;

	// Display state
	logic [SCR_W-1:0] scroll_q;
	logic [DIG_W-1:0] digit_q;
	logic [PWM_W-1:0] pwm_q;
	logic [7:0]       blink_cnt_q;
	logic [7:0]       spin_cnt_q;
	logic             phase_q;

	// Input stage
	logic             valid_s1;
	ssd_cmd_t         cmd_s1;
	logic [POS_W-1:0] pos_s1;
	logic [7:0]       code_s1;

	// Result register
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	logic             take;
	logic             is_disp;

	logic [SCR_W-1:0] scroll_d;
	logic [DIG_W-1:0] digit_d;
	logic [PWM_W-1:0] pwm_d;
	logic [7:0]       blink_cnt_d;
	logic [7:0]       spin_cnt_d;
	logic             phase_d;
	logic [SEG_W-1:0] seg_d;

	logic [6:0]       len_ext;
	logic [IW-1:0]    eff_len;
	logic [IW-1:0]    end_idx;
	logic [IW-1:0]    rd_idx;
	logic [IW-1:0]    rel_idx;
	logic             rd_in_msg;
	logic [SEG_W-1:0] rd_data;
	logic             buf_wr;
	logic             buf_clr;

	// Configuration port: always ready, write by index
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_mode_q  <= BLINK_OFF;
			spin_en_q     <= 1'b0;
			msg_len_q     <= 6'd0;
			spin_dly_q    <= 8'd1;
			blink_dly_q   <= 8'd1;
			dim_level_q   <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLINK_MODE:  blink_mode_q  <= cfg_data[2:0];
				REG_SPIN_EN:     spin_en_q     <= cfg_data[0];
				REG_MSG_LEN:     msg_len_q     <= cfg_data[5:0];
				REG_SPIN_DLY:    spin_dly_q    <= cfg_data;
				REG_BLINK_DLY:   blink_dly_q   <= cfg_data;
				REG_DIM_LEVEL:   dim_level_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage unless a display result has nowhere to go
	assign is_disp  = (cmd_s1 == CMD_DISP);
	assign take     = valid_s1 && (!is_disp || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= ssd_cmd_t'(s_tuser);
			pos_s1  <= s_tdata[POS_W-1:0];
			code_s1 <= s_tdata[POS_W +: 8];
		end
	end

	// Message length limited to the buffer size
	assign len_ext = 7'(msg_len_q);
	assign eff_len = (len_ext > 7'(MAX_CHARS)) ? IW'(MAX_CHARS) : IW'(len_ext);
	assign end_idx = eff_len + IW'(DIGITS);

	// Pattern buffer: loads behind the blank lead-in, clears blank everything
	assign buf_wr  = take && (cmd_s1 == CMD_LOAD) && (32'(pos_s1) < MAX_CHARS);
	assign buf_clr = take && (cmd_s1 == CMD_CLEAR);

	ssd_buf #(
		.MAX_CHARS(MAX_CHARS)
	) u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (buf_wr),
		.wr_addr (pos_s1),
		.wr_data (ssd_glyph(code_s1)),
		.clear   (buf_clr),
		.rd_addr (rel_idx[POS_W-1:0]),
		.rd_data (rd_data)
	);

	// Buffer read for the next digit; lead-in and past-message entries are blank
	assign rd_idx    = IW'(scroll_q) + IW'(digit_d);
	assign rel_idx   = rd_idx - IW'(DIGITS);
	assign rd_in_msg = (rd_idx >= IW'(DIGITS)) && (rd_idx < end_idx);

	// Next state for message and display ticks
	always_comb begin
		logic [PWM_W-1:0] pwm_cur;
		logic [PWM_W-1:0] pwm_nxt;
		logic             lit;
		logic             blink_hit;
		scroll_d    = scroll_q;
		digit_d     = (digit_q == DIG_W'(DIGITS - 1)) ? '0 : digit_q + 1'b1;
		pwm_d       = pwm_q;
		blink_cnt_d = blink_cnt_q;
		spin_cnt_d  = spin_cnt_q;
		phase_d     = phase_q;

		// Blink toggle counter
		if (blink_mode_q != BLINK_OFF) begin
			blink_cnt_d = blink_cnt_q - 8'd1;
			if (blink_cnt_d == 8'd0) begin
				blink_cnt_d = blink_dly_q;
				phase_d     = !phase_q;
			end
		end

		// Scroll counter; wrap past the end of the message to the start
		if (spin_en_q) begin
			spin_cnt_d = spin_cnt_q - 8'd1;
			if (spin_cnt_d == 8'd0) begin
				spin_cnt_d = spin_dly_q;
				if (IW'(scroll_q) > end_idx) begin
					scroll_d = '0;
				end else begin
					scroll_d = scroll_q + 1'b1;
				end
			end
		end else begin
			scroll_d = SCR_W'(DIGITS);
		end

		// PWM: lit while the count stays at or above the dim level
		pwm_cur = (pwm_q == '0) ? PWM_W'(PWM_PERIOD) : pwm_q;
		pwm_nxt = pwm_cur - 1'b1;
		lit     = 5'(pwm_nxt) >= 5'(dim_level_q);
		pwm_d   = (pwm_nxt == '0) ? PWM_W'(PWM_PERIOD) : pwm_nxt;

		// Blank the blinking digit during the dark phase
		blink_hit = (blink_mode_q == BLINK_EVERY)
			|| (({1'b0, blink_mode_q} - 4'd1) == 4'(digit_d));
		if (!phase_q && (blink_mode_q != BLINK_OFF) && blink_hit) begin
			lit = 1'b0;
		end

		seg_d = (lit && rd_in_msg) ? rd_data : SEG_BLANK;
	end

	// Commit state per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q    <= SCR_W'(DIGITS);
			digit_q     <= '0;
			pwm_q       <= PWM_W'(PWM_PERIOD);
			blink_cnt_q <= 8'd0;
			spin_cnt_q  <= 8'd0;
			phase_q     <= 1'b0;
		end else if (take) begin
			case (cmd_s1)
				CMD_CLEAR: begin
					scroll_q <= SCR_W'(DIGITS);
				end
				CMD_MSG: begin
					scroll_q    <= scroll_d;
					blink_cnt_q <= blink_cnt_d;
					spin_cnt_q  <= spin_cnt_d;
					phase_q     <= phase_d;
				end
				CMD_DISP: begin
					digit_q <= digit_d;
					pwm_q   <= pwm_d;
				end
				default: ;
			endcase
		end
	end

	// Result register: load on a display tick, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take && is_disp) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_disp) begin
			m_data_q <= OUT_W'({seg_d, digit_d});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* bench/tb_seven_segment_scroll_blink_driver.sv */
// ----------------------------------------------------------------------------
// tb_seven_segment_scroll_blink_driver
// Self-checking bench for the seven-segment scroll and blink driver. A
// scoreboard class tracks its own copy of the message buffer, the scroll,
// blink and PWM counters and predicts every display tick result. The bench
// has a directed opening, then configuration phases with random commands.
// Input bursts, output stalls and register settings, extremes included,
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb_seven_segment_scroll_blink_driver;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int DIGITS       = 4;
	localparam int MAX_CHARS    = 32;
	localparam int PWM_PERIOD   = 10;
	localparam int BUF_DEPTH    = MAX_CHARS + 2 * DIGITS;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 162;
	localparam int SETTLE       = 4;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [1:0]       digit;
		logic [SEG_W-1:0] seg;
	} disp_result_t;

	// Tracks driver state and holds the display results still owed
	class display_scoreboard;
		logic [2:0]       blink_mode;
		logic             spin_en;
		logic [5:0]       msg_len;
		logic [7:0]       spin_dly;
		logic [7:0]       blink_dly;
		logic [3:0]       dim_level;
		logic [SEG_W-1:0] patterns [BUF_DEPTH];
		logic [5:0]       scroll;
		logic [1:0]       digit;
		logic [3:0]       pwm;
		logic [7:0]       blink_cnt;
		logic [7:0]       spin_cnt;
		logic             blink_phase;
		disp_result_t     expected_q [$];
		int               n_errors;
		int               n_checked;

		function new();
			blink_mode  = BLINK_OFF;
			spin_en     = 1'b0;
			msg_len     = '0;
			spin_dly    = 8'd1;
			blink_dly   = 8'd1;
			dim_level   = 4'd1;
			foreach (patterns[i]) patterns[i] = SEG_BLANK;
			scroll      = 6'(DIGITS);
			digit       = '0;
			pwm         = 4'(PWM_PERIOD);
			blink_cnt   = '0;
			spin_cnt    = '0;
			blink_phase = 1'b0;
			n_errors    = 0;
			n_checked   = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				REG_BLINK_MODE:  blink_mode  = val[2:0];
				REG_SPIN_EN:     spin_en     = val[0];
				REG_MSG_LEN:     msg_len     = val[5:0];
				REG_SPIN_DLY:    spin_dly    = val;
				REG_BLINK_DLY:   blink_dly   = val;
				REG_DIM_LEVEL:   dim_level   = val[3:0];
				default: ;
			endcase
		endfunction

		// Apply one accepted input transaction and queue its result, if any
		function void note_input(ssd_cmd_t cmd, logic [4:0] pos, logic [7:0] code);
			int               eff;
			int               nxt;
			int               idx;
			logic             lit;
			logic [7:0]       uc;
			logic [SEG_W-1:0] seg;
			disp_result_t     res;
			eff = (msg_len > MAX_CHARS) ? MAX_CHARS : int'(msg_len);
			case (cmd)
				CMD_LOAD: begin
					uc = code;
					if (uc >= "a" && uc <= "z") begin
						uc = uc - 8'd32;
					end
					case (uc)
						"A": seg = 7'h77;  "B": seg = 7'h7C;  "C": seg = 7'h39;
						"D": seg = 7'h5E;  "E": seg = 7'h79;  "F": seg = 7'h71;
						"G": seg = 7'h6F;  "H": seg = 7'h74;  "I": seg = 7'h04;
						"J": seg = 7'h1E;  "L": seg = 7'h38;  "N": seg = 7'h54;
						"O": seg = 7'h3F;  "P": seg = 7'h73;  "Q": seg = 7'h67;
						"R": seg = 7'h50;  "S": seg = 7'h6D;  "T": seg = 7'h78;
						"U": seg = 7'h3E;  "V": seg = 7'h3E;  "Y": seg = 7'h6E;
						"Z": seg = 7'h7F;  "0": seg = 7'h3F;  "1": seg = 7'h06;
						"2": seg = 7'h5B;  "3": seg = 7'h4F;  "4": seg = 7'h66;
						"5": seg = 7'h6D;  "6": seg = 7'h7D;  "7": seg = 7'h07;
						"8": seg = 7'h7F;  "9": seg = 7'h6F;  "-": seg = 7'h40;
						"=": seg = 7'h48;
						default: seg = SEG_BLANK;
					endcase
					if (pos < MAX_CHARS) begin
						patterns[int'(pos) + DIGITS] = seg;
					end
				end
				CMD_CLEAR: begin
					foreach (patterns[i]) patterns[i] = SEG_BLANK;
					scroll = 6'(DIGITS);
				end
				CMD_MSG: begin
					// advance blink toggle, then the scroll position
					if (blink_mode != BLINK_OFF) begin
						blink_cnt = blink_cnt - 8'd1;
						if (blink_cnt == 8'd0) begin
							blink_cnt   = blink_dly;
							blink_phase = !blink_phase;
						end
					end
					if (spin_en) begin
						spin_cnt = spin_cnt - 8'd1;
						if (spin_cnt == 8'd0) begin
							spin_cnt = spin_dly;
							if (int'(scroll) > eff + DIGITS) begin
								scroll = '0;
							end else begin
								scroll = scroll + 6'd1;
							end
						end
					end else begin
						scroll = 6'(DIGITS);
					end
				end
				default: begin
					// step digit, run PWM, blank the blinking digit
					digit = digit + 2'd1;
					if (pwm == 4'd0) begin
						pwm = 4'(PWM_PERIOD);
					end
					nxt = int'(pwm) - 1;
					lit = (nxt >= int'(dim_level));
					pwm = (nxt == 0) ? 4'(PWM_PERIOD) : 4'(nxt);
					if (lit && !blink_phase && blink_mode != BLINK_OFF &&
					    (blink_mode == BLINK_EVERY ||
					     int'(digit) == int'(blink_mode) - 1)) begin
						lit = 1'b0;
					end
					seg = SEG_BLANK;
					if (lit) begin
						idx = int'(scroll) + int'(digit);
						if (idx < BUF_DEPTH && idx < eff + DIGITS) begin
							seg = patterns[idx];
						end
					end
					res.digit = digit;
					res.seg   = seg;
					expected_q.push_back(res);
				end
			endcase
		endfunction

		function void check_result(logic [1:0] d, logic [SEG_W-1:0] s);
			disp_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: digit_sel %0d segments 0x%02h", d, s);
				n_errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			n_checked++;
			if (d !== exp_res.digit) begin
				$error("digit_sel: expected %0d, got %0d", exp_res.digit, d);
				n_errors++;
			end
			if (s !== exp_res.seg) begin
				$error("segments: expected 0x%02h, got 0x%02h", exp_res.seg, s);
				n_errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	display_scoreboard sb;
	int          cycle_cnt   = 0;
	int          n_sent      = 0;
	int          burst_left  = 0;
	bit          gaps_on     = 1'b0;
	bit          stalls_on   = 1'b0;
	logic [15:0] ready_pat   = 16'hFFFF;
	int          ready_ptr   = 0;

	seven_segment_scroll_blink_driver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Stall the result stream on a rotating pattern
	always @(negedge clk) begin
		if (stalls_on) begin
			m_tready  <= ready_pat[ready_ptr];
			ready_ptr <= (ready_ptr + 1) % 16;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check each result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[1:0], m_tdata[8:2]);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb_seven_segment_scroll_blink_driver: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [2:0] mode, logic spin, logic [5:0] len,
	                         logic [7:0] sdel, logic [7:0] bdel, logic [3:0] dim);
		write_reg(REG_BLINK_MODE, {5'd0, mode});
		write_reg(REG_SPIN_EN, {7'd0, spin});
		write_reg(REG_MSG_LEN, {2'd0, len});
		write_reg(REG_SPIN_DLY, sdel);
		write_reg(REG_BLINK_DLY, bdel);
		write_reg(REG_DIM_LEVEL, {4'd0, dim});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Send one command transaction, inserting a random gap between bursts when gaps are on
	task automatic send_item(ssd_cmd_t cmd, logic [4:0] pos, logic [7:0] code);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'd0, code, pos};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, pos, code);
		n_sent++;
	endtask

	// Hold off until every owed result has arrived and the pipeline is empty
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic [7:0] pick_char();
		string charset;
		charset = "ABCDEFGHIJLNOPQRSTUVYZabcdefghijlnopqrstuvyz0123456789-=";
		return charset[$urandom_range(0, charset.len() - 1)];
	endfunction

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_item(CMD_DISP, 5'($urandom), 8'($urandom));
		end else if (r < 80) begin
			send_item(CMD_MSG, 5'($urandom), 8'($urandom));
		end else if (r < 97) begin
			send_item(CMD_LOAD, 5'($urandom),
			          ($urandom_range(0, 9) < 7) ? pick_char() : 8'($urandom));
		end else begin
			send_item(CMD_CLEAR, 5'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [2:0] mode;
		logic       spin;
		logic [5:0] len;
		logic [7:0] sdel;
		logic [7:0] bdel;
		logic [3:0] dim;
		int         start_cnt;
		int         eff;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset defaults, every glyph class, clear and ticks
		stalls_on = 1'b0;
		gaps_on   = 1'b0;
		repeat (2) send_item(CMD_DISP, 5'd0, 8'd0);
		drain();
		configure(BLINK_OFF, 1'b0, 6'd8, 8'd1, 8'd1, 4'd0);
		send_item(CMD_LOAD, 5'd0, "A");
		send_item(CMD_LOAD, 5'd1, "z");
		send_item(CMD_LOAD, 5'd2, "t");
		send_item(CMD_LOAD, 5'd3, "=");
		send_item(CMD_LOAD, 5'd4, "-");
		send_item(CMD_LOAD, 5'd5, 8'hFF);
		send_item(CMD_LOAD, 5'd6, "9");
		send_item(CMD_LOAD, 5'd7, 8'h00);
		send_item(CMD_LOAD, 5'd31, "8");
		repeat (4) send_item(CMD_DISP, 5'd31, 8'hFF);
		send_item(CMD_MSG, 5'd0, 8'd0);
		repeat (4) send_item(CMD_DISP, 5'd0, 8'd0);
		send_item(CMD_CLEAR, 5'd0, 8'd0);
		repeat (2) send_item(CMD_DISP, 5'd0, 8'd0);
		drain();

		// Random phases: early ones pin register extremes
		for (int p = 0; p < PHASES; p++) begin
			mode = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
			spin = (p % 3 != 2);
			case (p)
				1:       len = 6'd0;
				2:       len = 6'd63;
				3:       len = 6'd32;
				default: len = 6'($urandom_range(1, 32));
			endcase
			sdel = (p == 4) ? 8'd0 : (p == 5) ? 8'd255 : 8'($urandom_range(1, 3));
			bdel = (p == 4) ? 8'd0 : (p == 6) ? 8'd255 : 8'($urandom_range(1, 4));
			case (p)
				0:       dim = 4'd0;
				7:       dim = 4'd15;
				8:       dim = 4'd10;
				default: dim = 4'($urandom_range(0, 10));
			endcase
			configure(mode, spin, len, sdel, bdel, dim);
			gaps_on   = (p % 5 != 0);
			stalls_on = (p % 4 != 3);
			ready_pat = 16'($urandom) | 16'h0001;

			// Well-formed message load, then mixed traffic
			start_cnt = n_sent;
			if ($urandom_range(0, 1) == 1) begin
				send_item(CMD_CLEAR, 5'($urandom), 8'($urandom));
			end
			eff = (len > MAX_CHARS) ? MAX_CHARS : int'(len);
			for (int i = 0; i < eff; i++) begin
				send_item(CMD_LOAD, 5'(i), pick_char());
			end
			while (n_sent - start_cnt < PHASE_ITEMS) begin
				send_random();
			end
			drain();
		end

		$display("Run covered %0d command transactions in %0d register phases, %0d results checked.",
		         n_sent, PHASES + 1, sb.n_checked);
		$display("Settings swept blink modes 0-7, dim 0/10/15, delays 0 and 255, length 0 to 63.");
		if (sb.n_errors == 0) begin
			$display("tb_seven_segment_scroll_blink_driver: PASS");
		end else begin
			$display("tb_seven_segment_scroll_blink_driver: FAIL");
		end
		$finish;
	end

endmodule
